[design/pht_pkg.sv]
// types and constants shared by the handle table block and its checker
package pht_pkg;

    localparam int PID_W    = 15;
    localparam int HANDLE_W = 8;
    localparam int INODE_W  = 16;
    localparam int OFF_W    = 31;
    localparam int POS_W    = 32;
    localparam int IOUT_W   = 17;

    localparam logic [IOUT_W-1:0] INODE_NONE = '1;
    localparam logic [POS_W-1:0]  POS_NONE   = '1;

    typedef enum logic [2:0] {
        CMD_OPEN        = 3'd0,
        CMD_SEEK_HANDLE = 3'd1,
        CMD_SEEK_INODE  = 3'd2,
        CMD_CLOSE_HANDLE = 3'd3,
        CMD_CLOSE_INODE = 3'd4,
        CMD_LOOKUP      = 3'd5,
        CMD_CHECK_INODE = 3'd6,
        CMD_CLAIM       = 3'd7
    } t_cmd;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SLOT   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_SCAN   = 6'b010000,
        S_HCHK   = 6'b100000
    } t_state;

    typedef struct packed {
        logic               used;
        logic [INODE_W-1:0] inode;
        logic [POS_W-1:0]   position;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_FREE = '{used: 1'b0, inode: '0, position: POS_NONE};

endpackage

[design/per_process_handle_table.sv]
// per-process handle table: slot scan, entry ram and command sequencer
//
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with o_valid and cannot be held off. After reset the
// block runs a clearing pass over every entry of the entry ram with busy
// high. Every command except the inode check first walks the slot owners one
// per cycle and then decides in S_DECIDE. Claim then finishes; seek, close
// and lookup by handle take one ram read more; open and seek or close by
// inode walk the entries of the process's slot through the one-read-port
// entry ram. The inode check walks the entries of all slots until it finds a
// match. The result strobe comes in the first cycle with busy low.
module per_process_handle_table #(
    parameter int NUM_SLOTS        = 16,
    parameter int ENTRIES_PER_SLOT = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pht_pkg::t_cmd                      i_cmd,
    input  logic [pht_pkg::PID_W-1:0]          i_proc_id,
    input  logic [pht_pkg::HANDLE_W-1:0]       i_handle,
    input  logic [pht_pkg::INODE_W-1:0]        i_inode,
    input  logic [pht_pkg::OFF_W-1:0]          i_new_offset,
    output logic                               o_valid,
    output logic                               o_status,
    output logic [pht_pkg::HANDLE_W-1:0]       o_handle_out,
    output logic signed [pht_pkg::IOUT_W-1:0]  o_inode_out,
    output logic signed [pht_pkg::POS_W-1:0]   o_offset_out
);

    import pht_pkg::*;

    localparam int TOTAL  = NUM_SLOTS * ENTRIES_PER_SLOT;
    localparam int SLOT_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int ENT_W  = ENTRIES_PER_SLOT > 1 ? $clog2(ENTRIES_PER_SLOT) : 1;
    localparam int ADDR_W = TOTAL > 1 ? $clog2(TOTAL) : 1;
    localparam int CNT_W  = $clog2(TOTAL + 1);

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [PID_W-1:0]     r_pid, n_pid;
    logic [HANDLE_W-1:0]  r_handle, n_handle;
    logic [INODE_W-1:0]   r_inode, n_inode;
    logic [OFF_W-1:0]     r_off, n_off;

    logic                 r_claimed [NUM_SLOTS];
    logic                 n_claimed [NUM_SLOTS];
    logic [PID_W-1:0]     r_owner [NUM_SLOTS];
    logic [PID_W-1:0]     n_owner [NUM_SLOTS];

    logic [SLOT_W-1:0]    r_scnt, n_scnt;
    logic                 r_own_vld, n_own_vld;
    logic [SLOT_W-1:0]    r_own_idx, n_own_idx;
    logic                 r_free_vld, n_free_vld;
    logic [SLOT_W-1:0]    r_free_idx, n_free_idx;

    logic [ADDR_W-1:0]    r_base, n_base;
    logic [CNT_W-1:0]     r_acnt, n_acnt;
    logic [CNT_W-1:0]     r_limit, n_limit;
    logic                 r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]    r_rd_idx, n_rd_idx;

    logic                 r_valid, n_valid;
    logic                 r_status, n_status;
    logic [HANDLE_W-1:0]  r_hout, n_hout;
    logic [IOUT_W-1:0]    r_iout, n_iout;
    logic [POS_W-1:0]     r_oout, n_oout;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    t_entry               ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    t_entry               rd;
    logic [SLOT_W-1:0]    sel_slot;
    logic [ADDR_W-1:0]    base_c;
    logic [ADDR_W-1:0]    hidx;
    logic                 hvalid;
    logic                 hit;
    logic                 issuing;

    pht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_entry'(ram_rdata);
    assign sel_slot = r_own_vld ? r_own_idx : r_free_idx;
    assign base_c   = ADDR_W'(int'(sel_slot) * ENTRIES_PER_SLOT);
    assign hidx     = ADDR_W'(r_handle[ENT_W-1:0]);
    assign hvalid   = r_handle < HANDLE_W'(ENTRIES_PER_SLOT);
    assign issuing  = r_acnt < r_limit;
    assign hit      = r_rd_vld && ((r_cmd == CMD_OPEN) ? !rd.used
                                   : (rd.used && rd.inode == r_inode));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_pid      = r_pid;
        n_handle   = r_handle;
        n_inode    = r_inode;
        n_off      = r_off;
        n_claimed  = r_claimed;
        n_owner    = r_owner;
        n_scnt     = r_scnt;
        n_own_vld  = r_own_vld;
        n_own_idx  = r_own_idx;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_base     = r_base;
        n_acnt     = r_acnt;
        n_limit    = r_limit;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_hout     = r_hout;
        n_iout     = r_iout;
        n_oout     = r_oout;
        ram_we     = 1'b0;
        ram_waddr  = r_base + r_rd_idx;
        ram_wdata  = ENTRY_FREE;
        ram_raddr  = r_base + ADDR_W'(r_acnt);

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_acnt);
                ram_wdata = ENTRY_FREE;
                if (r_acnt == CNT_W'(TOTAL - 1)) begin
                    n_acnt  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_acnt = r_acnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd      = i_cmd;
                    n_pid      = i_proc_id;
                    n_handle   = i_handle;
                    n_inode    = i_inode;
                    n_off      = i_new_offset;
                    n_status   = 1'b1;
                    n_hout     = '0;
                    n_iout     = (i_cmd == CMD_LOOKUP) ? INODE_NONE : '0;
                    n_oout     = (i_cmd == CMD_LOOKUP) ? POS_NONE : '0;
                    n_scnt     = '0;
                    n_own_vld  = 1'b0;
                    n_free_vld = 1'b0;
                    n_rd_vld   = 1'b0;
                    n_acnt     = '0;
                    if (i_cmd == CMD_CHECK_INODE) begin
                        n_base  = '0;
                        n_limit = CNT_W'(TOTAL);
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                if (r_claimed[r_scnt] && r_owner[r_scnt] == r_pid && !r_own_vld) begin
                    n_own_vld = 1'b1;
                    n_own_idx = r_scnt;
                end
                if (!r_claimed[r_scnt] && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_scnt;
                end
                if (r_scnt == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_scnt = r_scnt + 1'b1;
                end
            end
            S_DECIDE: begin
                n_base    = base_c;
                n_acnt    = '0;
                n_limit   = CNT_W'(ENTRIES_PER_SLOT);
                n_rd_vld  = 1'b0;
                ram_raddr = base_c + hidx;
                case (r_cmd)
                    CMD_CLAIM: begin
                        if (r_free_vld) begin
                            n_claimed[r_free_idx] = 1'b1;
                            n_owner[r_free_idx]   = r_pid;
                            n_status              = 1'b0;
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_OPEN: begin
                        if (r_own_vld) begin
                            n_state = S_SCAN;
                        end else if (r_free_vld) begin
                            n_claimed[r_free_idx] = 1'b1;
                            n_owner[r_free_idx]   = r_pid;
                            n_state               = S_SCAN;
                        end else begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    CMD_SEEK_INODE, CMD_CLOSE_INODE: begin
                        if (r_own_vld) begin
                            n_state = S_SCAN;
                        end else begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (r_own_vld && hvalid) begin
                            n_state = S_HCHK;
                        end else begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (hit) begin
                    n_status = 1'b0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    case (r_cmd)
                        CMD_OPEN: begin
                            ram_we    = 1'b1;
                            ram_wdata = '{used: 1'b1, inode: r_inode, position: '0};
                            n_hout    = HANDLE_W'(r_rd_idx);
                        end
                        CMD_SEEK_INODE: begin
                            ram_we    = 1'b1;
                            ram_wdata = '{used: 1'b1, inode: rd.inode,
                                          position: {1'b0, r_off}};
                        end
                        CMD_CLOSE_INODE: begin
                            ram_we    = 1'b1;
                            ram_wdata = ENTRY_FREE;
                        end
                        default: begin
                        end
                    endcase
                end else if (issuing) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = ADDR_W'(r_acnt);
                    n_acnt   = r_acnt + 1'b1;
                end else if (!r_rd_vld) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_rd_vld = 1'b0;
                end
            end
            S_HCHK: begin
                ram_waddr = r_base + hidx;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
                case (r_cmd)
                    CMD_SEEK_HANDLE: begin
                        ram_we    = 1'b1;
                        ram_wdata = '{used: rd.used, inode: rd.inode,
                                      position: {1'b0, r_off}};
                        n_status  = 1'b0;
                    end
                    CMD_CLOSE_HANDLE: begin
                        if (rd.used) begin
                            ram_we    = 1'b1;
                            ram_wdata = ENTRY_FREE;
                            n_status  = 1'b0;
                        end
                    end
                    default: begin
                        n_status = 1'b0;
                        n_iout   = rd.used ? {1'b0, rd.inode} : INODE_NONE;
                        n_oout   = rd.position;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_acnt  <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_claimed[i] <= 1'b0;
            end
        end else begin
            r_state   <= n_state;
            r_acnt    <= n_acnt;
            r_valid   <= n_valid;
            r_claimed <= n_claimed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pid      <= n_pid;
        r_handle   <= n_handle;
        r_inode    <= n_inode;
        r_off      <= n_off;
        r_owner    <= n_owner;
        r_scnt     <= n_scnt;
        r_own_vld  <= n_own_vld;
        r_own_idx  <= n_own_idx;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_base     <= n_base;
        r_limit    <= n_limit;
        r_rd_vld   <= n_rd_vld;
        r_rd_idx   <= n_rd_idx;
        r_status   <= n_status;
        r_hout     <= n_hout;
        r_iout     <= n_iout;
        r_oout     <= n_oout;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_handle_out = r_hout;
    assign o_inode_out  = $signed(r_iout);
    assign o_offset_out = $signed(r_oout);

endmodule

[design/pht_ram.sv]
// generic single write port ram with one registered read port
module pht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/pht_checker.sv]
// port-level checks for the handle table block and the bind that attaches them
module pht_port_checks (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  pht_pkg::t_cmd                      i_cmd,
    input  logic                               o_valid,
    input  logic                               o_status,
    input  logic [pht_pkg::HANDLE_W-1:0]       o_handle_out,
    input  logic signed [pht_pkg::IOUT_W-1:0]  o_inode_out,
    input  logic signed [pht_pkg::POS_W-1:0]   o_offset_out
);

    import pht_pkg::*;

    t_cmd r_cmd;

    // command of the beat in flight
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a finished command");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd != CMD_LOOKUP) |->
        (o_inode_out == '0 && o_offset_out == '0 &&
         (r_cmd == CMD_OPEN || o_handle_out == '0)))
        else $error("non-lookup result carries lookup or handle fields");

    a_failed_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd == CMD_LOOKUP && o_status) |->
        (o_inode_out == -17'sd1 && o_offset_out == -32'sd1))
        else $error("failed lookup does not report minus one");

    a_open_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd == CMD_OPEN && o_status) |-> (o_handle_out == '0))
        else $error("failed open returns a handle");

endmodule

bind per_process_handle_table pht_port_checks u_pht_port_checks (.*);
